[rtl/cmcf_pkg.sv]
package cmcf_pkg;

  localparam int COORD_W = 12;
  localparam int RAD_W   = 26;
  localparam int SQ_W    = 24;   // (2^12 - 1)^2 fits in 24 bits
  localparam int CH_W    = 8;
  localparam int NCH     = 3;    // 0 red, 1 green, 2 blue
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 25;
  localparam int REM_W   = SUM_W + 1;
  localparam int STEP_W  = 3;    // eight quotient bits

  // mid queue between front and back
  localparam int QPTR_W  = 2;
  localparam int QDEPTH  = 1 << QPTR_W;
  localparam int QCNT_W  = QPTR_W + 1;

  // output buffer in the back end
  localparam int OB_PTR_W = 1;
  localparam int OB_DEPTH = 1 << OB_PTR_W;
  localparam int OB_CNT_W = OB_PTR_W + 1;

  // request codes on the input channel
  localparam logic [1:0] REQ_MEASURE = 2'd0;
  localparam logic [1:0] REQ_FINISH  = 2'd1;
  localparam logic [1:0] REQ_FILL    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS2  = 2'd2;

  typedef logic [NCH-1:0][CH_W-1:0]  color_t;
  typedef logic [NCH-1:0][SUM_W-1:0] sums_t;

  typedef enum logic [1:0] {
    KIND_MEASURE = 2'd0,
    KIND_FINISH  = 2'd1,
    KIND_FILL    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t  kind;
    logic   hit;
    color_t color;
  } entry_t;

  typedef struct packed {
    logic   is_mean;
    logic   hit;
    logic   empty_disc;
    color_t color;
  } res_t;

endpackage

[rtl/cmcf_front.sv]
module cmcf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        req_type,
  input  logic [cmcf_pkg::COORD_W-1:0]      pixel_x,
  input  logic [cmcf_pkg::COORD_W-1:0]      pixel_y,
  input  cmcf_pkg::color_t                  color,
  input  logic [cmcf_pkg::COORD_W-1:0]      center_x,
  input  logic [cmcf_pkg::COORD_W-1:0]      center_y,
  input  logic [cmcf_pkg::RAD_W-1:0]        radius_squared,
  input  logic [cmcf_pkg::QCNT_W-1:0]       q_count,
  output logic                              q_push,
  output cmcf_pkg::entry_t                  q_entry
);
  import cmcf_pkg::*;

  logic                    v1_r, v2_r;
  logic [1:0]              req1_r, req2_r;
  logic [COORD_W-1:0]      px1_r, py1_r;
  color_t                  col1_r, col2_r;
  logic [SQ_W-1:0]         sqx2_r, sqy2_r;
  logic signed [COORD_W:0] dx, dy;
  logic signed [2*COORD_W+1:0] dxx, dyy;
  logic [SQ_W:0]           d2;
  logic                    hit;
  logic [QCNT_W:0]         in_flight;
  logic                    accept;

  // credit check: queue entries plus items still in the pipe
  assign in_flight = {1'b0, q_count} + (QCNT_W+1)'(v1_r) + (QCNT_W+1)'(v2_r);
  assign full      = in_flight >= (QCNT_W+1)'(QDEPTH);
  assign accept    = push && !full;

  assign dx  = $signed({1'b0, px1_r}) - $signed({1'b0, center_x});
  assign dy  = $signed({1'b0, py1_r}) - $signed({1'b0, center_y});
  assign dxx = dx * dx;
  assign dyy = dy * dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req1_r <= req_type;
      px1_r  <= pixel_x;
      py1_r  <= pixel_y;
      col1_r <= color;
    end
    req2_r <= req1_r;
    col2_r <= col1_r;
    sqx2_r <= dxx[SQ_W-1:0];
    sqy2_r <= dyy[SQ_W-1:0];
  end

  // 12-bit coordinates always lie in the image, so only the distance counts
  assign d2  = {1'b0, sqx2_r} + {1'b0, sqy2_r};
  assign hit = {1'b0, d2} <= radius_squared;

  always_comb begin
    q_push        = 1'b0;
    q_entry.kind  = KIND_MEASURE;
    q_entry.hit   = hit;
    q_entry.color = col2_r;
    case (req2_r)
      REQ_MEASURE: begin
        q_push       = v2_r && hit;   // outside pixels leave no trace
        q_entry.kind = KIND_MEASURE;
      end
      REQ_FINISH: begin
        q_push       = v2_r;
        q_entry.kind = KIND_FINISH;
      end
      REQ_FILL: begin
        q_push       = v2_r;
        q_entry.kind = KIND_FILL;
      end
      default: q_push = 1'b0;
    endcase
  end

endmodule

[rtl/cmcf_queue.sv]
module cmcf_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  cmcf_pkg::entry_t            wr_data,
  input  logic                        rd_en,
  output cmcf_pkg::entry_t            rd_data,
  output logic                        not_empty,
  output logic [cmcf_pkg::QCNT_W-1:0] count
);
  import cmcf_pkg::*;

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign not_empty = cnt_r != '0;
  assign count     = cnt_r;
  assign rd_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(wr_en);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(rd_en);
    cnt_nxt    = cnt_r + QCNT_W'(wr_en) - QCNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/cmcf_div.sv]
module cmcf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  cmcf_pkg::sums_t               sums,
  input  logic [cmcf_pkg::CNT_W-1:0]    count,
  output logic                          busy,
  output cmcf_pkg::color_t              mean,
  output logic                          zero_count
);
  import cmcf_pkg::*;

  logic                      busy_r;
  logic [STEP_W-1:0]         step_r;
  logic [REM_W-1:0]          rem_r [NCH];
  logic [REM_W-1:0]          dsr_r;
  logic [CH_W-1:0]           q_r   [NCH];
  logic [NCH-1:0]            clamp_r;
  logic                      zero_r;
  logic [NCH-1:0]            ge;

  assign busy       = busy_r;
  assign zero_count = zero_r;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      ge[i] = rem_r[i] >= dsr_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      if (zero_r) begin
        mean[i] = '0;
      end else if (clamp_r[i]) begin
        mean[i] = '1;
      end else begin
        mean[i] = q_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && step_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  // restoring division, one quotient bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= '1;
      dsr_r  <= {1'b0, count, 7'b0};
      zero_r <= count == '0;
      for (int i = 0; i < NCH; i++) begin
        rem_r[i]   <= {1'b0, sums[i]};
        q_r[i]     <= '0;
        clamp_r[i] <= {1'b0, sums[i]} >= {count, 8'b0};
      end
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      dsr_r  <= dsr_r >> 1;
      for (int i = 0; i < NCH; i++) begin
        rem_r[i] <= ge[i] ? rem_r[i] - dsr_r : rem_r[i];
        q_r[i]   <= {q_r[i][CH_W-2:0], ge[i]};
      end
    end
  end

endmodule

[rtl/cmcf_back.sv]
module cmcf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  cmcf_pkg::entry_t  q_entry,
  output logic              q_pop,
  output cmcf_pkg::res_t    res,
  output logic              empty,
  input  logic              pop
);
  import cmcf_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  sums_t                sums_r, sums_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  color_t               mean_r, mean_nxt;
  res_t                 ob_q [OB_DEPTH];
  logic [OB_PTR_W-1:0]  ob_wr_r, ob_rd_r;
  logic [OB_CNT_W-1:0]  ob_cnt_r, ob_cnt_nxt;
  logic                 ob_push, ob_pop, ob_room;
  res_t                 ob_data;
  logic                 div_start;
  logic                 div_busy;
  color_t               div_mean;
  logic                 div_zero;
  logic [SUM_W:0]       acc [NCH];

  cmcf_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .sums       (sums_r),
    .count      (cnt_r),
    .busy       (div_busy),
    .mean       (div_mean),
    .zero_count (div_zero)
  );

  assign ob_room = ob_cnt_r != OB_CNT_W'(OB_DEPTH);
  assign empty   = ob_cnt_r == '0;
  assign ob_pop  = pop && !empty;
  assign res     = ob_q[ob_rd_r];

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      acc[i] = {1'b0, sums_r[i]} + (SUM_W+1)'(q_entry.color[i]);
    end
  end

  always_comb begin
    state_nxt          = state_r;
    sums_nxt           = sums_r;
    cnt_nxt            = cnt_r;
    mean_nxt           = mean_r;
    q_pop              = 1'b0;
    ob_push            = 1'b0;
    div_start          = 1'b0;
    ob_data.is_mean    = 1'b0;
    ob_data.hit        = q_entry.hit;
    ob_data.empty_disc = 1'b0;
    ob_data.color      = q_entry.hit ? mean_r : q_entry.color;
    case (state_r)
      ST_RUN: begin
        if (q_not_empty) begin
          case (q_entry.kind)
            KIND_MEASURE: begin
              q_pop = 1'b1;
              for (int i = 0; i < NCH; i++) begin
                sums_nxt[i] = acc[i][SUM_W] ? '1 : acc[i][SUM_W-1:0];
              end
              if (cnt_r != '1) begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            KIND_FILL: begin
              if (ob_room) begin
                q_pop   = 1'b1;
                ob_push = 1'b1;
              end
            end
            KIND_FINISH: begin
              // divider samples the sums now, so they clear at once
              q_pop     = 1'b1;
              div_start = 1'b1;
              sums_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = ST_DIV;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_DIV: begin
        ob_data.is_mean    = 1'b1;
        ob_data.hit        = 1'b0;
        ob_data.empty_disc = div_zero;
        ob_data.color      = div_mean;
        if (!div_busy && ob_room) begin
          ob_push   = 1'b1;
          mean_nxt  = div_mean;
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    ob_cnt_nxt = ob_cnt_r + OB_CNT_W'(ob_push) - OB_CNT_W'(ob_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      sums_r   <= '0;
      cnt_r    <= '0;
      mean_r   <= '0;
      ob_wr_r  <= '0;
      ob_rd_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      sums_r   <= sums_nxt;
      cnt_r    <= cnt_nxt;
      mean_r   <= mean_nxt;
      ob_wr_r  <= ob_wr_r + OB_PTR_W'(ob_push);
      ob_rd_r  <= ob_rd_r + OB_PTR_W'(ob_pop);
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_q[ob_wr_r] <= ob_data;
    end
  end

endmodule

[rtl/circle_mean_color_fill_top.sv]
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// input     | push / full            | in_req_type, in_pixel_x/y, in_red/green/blue_in
// result    | empty / pop            | out_is_mean, out_inside_res, out_empty_disc,
//           |                        | out_red/green/blue_out
// config    | psel penable pwrite    | paddr, pwdata, prdata (center_x 0x0,
//           | pready (always high)   | center_y 0x4, radius_squared 0x8)
//
// measure and fill items go at one per cycle while full is low and, for fill,
// the output buffer has room; a fill result passes both front stages, the mid
// queue and the output buffer before it shows on the result ports.
// a finish item holds the back end while it loads the divider, runs its eight
// one-bit-per-cycle restoring steps and emits the mean once the buffer has room.
// reset is synchronous and clears control state, sums, count and fill colour;
// no clearing pass is needed.
// a stalled result side fills the two-entry output buffer, then the mid queue;
// full rises once queue entries plus items in the two front stages reach four.
module circle_mean_color_fill_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      in_req_type,
  input  logic [cmcf_pkg::COORD_W-1:0]    in_pixel_x,
  input  logic [cmcf_pkg::COORD_W-1:0]    in_pixel_y,
  input  logic [cmcf_pkg::CH_W-1:0]       in_red_in,
  input  logic [cmcf_pkg::CH_W-1:0]       in_green_in,
  input  logic [cmcf_pkg::CH_W-1:0]       in_blue_in,
  // result channel
  output logic                            empty,
  input  logic                            pop,
  output logic                            out_is_mean,
  output logic                            out_inside_res,
  output logic                            out_empty_disc,
  output logic [cmcf_pkg::CH_W-1:0]       out_red_out,
  output logic [cmcf_pkg::CH_W-1:0]       out_green_out,
  output logic [cmcf_pkg::CH_W-1:0]       out_blue_out,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import cmcf_pkg::*;

  logic [COORD_W-1:0] center_x_r;
  logic [COORD_W-1:0] center_y_r;
  logic [RAD_W-1:0]   radius_sq_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  color_t             in_color;
  logic [QCNT_W-1:0]  q_count;
  logic               q_push, q_pop, q_not_empty;
  entry_t             q_wr_entry, q_rd_entry;
  res_t               res;

  // register file, written on the access phase of a write transfer
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      radius_sq_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTER_X: center_x_r  <= pwdata[COORD_W-1:0];
        REG_CENTER_Y: center_y_r  <= pwdata[COORD_W-1:0];
        REG_RADIUS2:  radius_sq_r <= pwdata[RAD_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_X: prdata = 32'(center_x_r);
      REG_CENTER_Y: prdata = 32'(center_y_r);
      REG_RADIUS2:  prdata = 32'(radius_sq_r);
      default:      prdata = '0;
    endcase
  end

  assign in_color[0] = in_red_in;
  assign in_color[1] = in_green_in;
  assign in_color[2] = in_blue_in;

  // front: takes transfers, squares the offsets, classifies against the disc
  cmcf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .req_type       (in_req_type),
    .pixel_x        (in_pixel_x),
    .pixel_y        (in_pixel_y),
    .color          (in_color),
    .center_x       (center_x_r),
    .center_y       (center_y_r),
    .radius_squared (radius_sq_r),
    .q_count        (q_count),
    .q_push         (q_push),
    .q_entry        (q_wr_entry)
  );

  // decouples the classifier from the accumulate / divide / emit side
  cmcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_push),
    .wr_data   (q_wr_entry),
    .rd_en     (q_pop),
    .rd_data   (q_rd_entry),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  // back: saturating sums, mean division, fill colour and output buffer
  cmcf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_entry     (q_rd_entry),
    .q_pop       (q_pop),
    .res         (res),
    .empty       (empty),
    .pop         (pop)
  );

  assign out_is_mean    = res.is_mean;
  assign out_inside_res = res.hit;
  assign out_empty_disc = res.empty_disc;
  assign out_red_out    = res.color[0];
  assign out_green_out  = res.color[1];
  assign out_blue_out   = res.color[2];

endmodule

[rtl/cmcf_checker.sv]
module cmcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       pready,
  input logic       out_is_mean,
  input logic       out_inside_res,
  input logic       out_empty_disc,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out
);

  // the output buffer comes out of reset drained and the input side not full
  a_reset_drained: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queue not drained after reset");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

  // a waiting result holds until it is taken
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_is_mean) && $stable(out_inside_res)
      && $stable(out_empty_disc) && $stable(out_red_out)
      && $stable(out_green_out) && $stable(out_blue_out))
    else $error("waiting result changed");

  a_mean_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_is_mean |-> !out_inside_res)
    else $error("mean result flagged inside");

  a_fill_not_empty_disc: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_is_mean |-> !out_empty_disc)
    else $error("fill result flagged empty disc");

endmodule

bind circle_mean_color_fill_top cmcf_checker u_checker (.*);
